/* hdl/srs_pkg.sv */
// shared types, constants and control store for the shift-register random source
// no dependencies; imported by shift_register_random_source and its testbench
package srs_pkg;

  localparam int OP_W   = 3;
  localparam int SEED_W = 31;
  localparam int MAXV_W = 15;
  localparam int THR_W  = 8;
  localparam int WORD_W = 16;
  localparam int PC_W   = 5;
  localparam int MOD7_W   = 3;
  localparam int MOD23_W  = 5;
  localparam int ROLL_W   = 7;

  // seed residue datapath
  localparam int SUM7_W        = 7;
  localparam int SEED_DIGITS   = 10;
  localparam int CHUNK23_W     = 11;
  localparam int SUM23_W       = 13;
  localparam int QUOT23_W      = 8;
  localparam int RECIP23_SHIFT = 17;
  localparam logic [SUM23_W-1:0] RECIP23 = 13'd5699;

  localparam logic [OP_W-1:0] OP_RESEED = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_RAW    = 3'd2;
  localparam logic [OP_W-1:0] OP_RANGED = 3'd3;
  localparam logic [OP_W-1:0] OP_ROLL   = 3'd4;
  localparam logic [OP_W-1:0] OP_ROLL2  = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam logic [MOD7_W-1:0]  MOD_SMALL = 3'd7;
  localparam logic [MOD23_W-1:0] MOD_LARGE = 5'd23;
  localparam logic [ROLL_W-1:0]  ROLL_SCALE = 7'd100;

  localparam logic [WORD_W-1:0] SEED_TABLE [8] = '{
    16'hA36E, 16'h924E, 16'hB784, 16'h4F67,
    16'h8092, 16'h592D, 16'h8E70, 16'hA794
  };

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SEED_W-1:0] seed;
    logic [MAXV_W-1:0] max_value;
    logic [THR_W-1:0]  threshold;
    logic [WORD_W-1:0] load_low;
    logic [WORD_W-1:0] load_mid;
    logic [WORD_W-1:0] load_high;
  } srs_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              hit;
    logic [WORD_W-1:0] state_low;
    logic [WORD_W-1:0] state_mid;
    logic [WORD_W-1:0] state_high;
  } srs_out_t;

  // datapath actions
  localparam logic [3:0] ACT_NOP     = 4'd0;
  localparam logic [3:0] ACT_FINISH  = 4'd1;
  localparam logic [3:0] ACT_LATCH   = 4'd2;
  localparam logic [3:0] ACT_FOLD    = 4'd3;
  localparam logic [3:0] ACT_SEEDLD  = 4'd4;
  localparam logic [3:0] ACT_BURN    = 4'd5;
  localparam logic [3:0] ACT_LOAD    = 4'd6;
  localparam logic [3:0] ACT_GEN     = 4'd7;
  localparam logic [3:0] ACT_MULMAX  = 4'd8;
  localparam logic [3:0] ACT_MUL100  = 4'd9;
  localparam logic [3:0] ACT_SAVEA   = 4'd10;
  localparam logic [3:0] ACT_AVG     = 4'd11;
  localparam logic [3:0] ACT_QUOT    = 4'd12;
  localparam logic [3:0] ACT_RESID   = 4'd13;

  // jump conditions
  localparam logic [2:0] COND_NEXT      = 3'd0;
  localparam logic [2:0] COND_ALWAYS    = 3'd1;
  localparam logic [2:0] COND_OUT_BUSY  = 3'd2;
  localparam logic [2:0] COND_NO_IN     = 3'd3;
  localparam logic [2:0] COND_DISPATCH  = 3'd4;
  localparam logic [2:0] COND_BURN_NONE = 3'd5;
  localparam logic [2:0] COND_BURN_MORE = 3'd6;

  // program addresses
  localparam logic [PC_W-1:0] ADDR_FIN      = 5'd0;
  localparam logic [PC_W-1:0] ADDR_IDLE     = 5'd1;
  localparam logic [PC_W-1:0] ADDR_DISPATCH = 5'd2;
  localparam logic [PC_W-1:0] ADDR_MOD      = 5'd3;
  localparam logic [PC_W-1:0] ADDR_MOD_Q    = 5'd4;
  localparam logic [PC_W-1:0] ADDR_MOD_R    = 5'd5;
  localparam logic [PC_W-1:0] ADDR_SEEDLD   = 5'd6;
  localparam logic [PC_W-1:0] ADDR_BURN     = 5'd7;
  localparam logic [PC_W-1:0] ADDR_BURN_END = 5'd8;
  localparam logic [PC_W-1:0] ADDR_LOAD     = 5'd9;
  localparam logic [PC_W-1:0] ADDR_RAW      = 5'd10;
  localparam logic [PC_W-1:0] ADDR_RANGED   = 5'd11;
  localparam logic [PC_W-1:0] ADDR_RANGED_M = 5'd12;
  localparam logic [PC_W-1:0] ADDR_ROLL     = 5'd13;
  localparam logic [PC_W-1:0] ADDR_ROLL_M   = 5'd14;
  localparam logic [PC_W-1:0] ADDR_ROLL2    = 5'd15;
  localparam logic [PC_W-1:0] ADDR_ROLL2_M1 = 5'd16;
  localparam logic [PC_W-1:0] ADDR_ROLL2_SA = 5'd17;
  localparam logic [PC_W-1:0] ADDR_ROLL2_G2 = 5'd18;
  localparam logic [PC_W-1:0] ADDR_ROLL2_M2 = 5'd19;
  localparam logic [PC_W-1:0] ADDR_ROLL2_AV = 5'd20;

  typedef struct packed {
    logic [3:0]      act;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t uw;
    unique case (pc)
      ADDR_FIN:      uw = '{ACT_FINISH, COND_OUT_BUSY,  ADDR_FIN};
      ADDR_IDLE:     uw = '{ACT_LATCH,  COND_NO_IN,     ADDR_IDLE};
      ADDR_DISPATCH: uw = '{ACT_NOP,    COND_DISPATCH,  ADDR_FIN};
      ADDR_MOD:      uw = '{ACT_FOLD,   COND_NEXT,      ADDR_FIN};
      ADDR_MOD_Q:    uw = '{ACT_QUOT,   COND_NEXT,      ADDR_FIN};
      ADDR_MOD_R:    uw = '{ACT_RESID,  COND_NEXT,      ADDR_FIN};
      ADDR_SEEDLD:   uw = '{ACT_SEEDLD, COND_BURN_NONE, ADDR_FIN};
      ADDR_BURN:     uw = '{ACT_BURN,   COND_BURN_MORE, ADDR_BURN};
      ADDR_BURN_END: uw = '{ACT_NOP,    COND_ALWAYS,    ADDR_FIN};
      ADDR_LOAD:     uw = '{ACT_LOAD,   COND_ALWAYS,    ADDR_FIN};
      ADDR_RAW:      uw = '{ACT_GEN,    COND_ALWAYS,    ADDR_FIN};
      ADDR_RANGED:   uw = '{ACT_GEN,    COND_NEXT,      ADDR_FIN};
      ADDR_RANGED_M: uw = '{ACT_MULMAX, COND_ALWAYS,    ADDR_FIN};
      ADDR_ROLL:     uw = '{ACT_GEN,    COND_NEXT,      ADDR_FIN};
      ADDR_ROLL_M:   uw = '{ACT_MUL100, COND_ALWAYS,    ADDR_FIN};
      ADDR_ROLL2:    uw = '{ACT_GEN,    COND_NEXT,      ADDR_FIN};
      ADDR_ROLL2_M1: uw = '{ACT_MUL100, COND_NEXT,      ADDR_FIN};
      ADDR_ROLL2_SA: uw = '{ACT_SAVEA,  COND_NEXT,      ADDR_FIN};
      ADDR_ROLL2_G2: uw = '{ACT_GEN,    COND_NEXT,      ADDR_FIN};
      ADDR_ROLL2_M2: uw = '{ACT_MUL100, COND_NEXT,      ADDR_FIN};
      ADDR_ROLL2_AV: uw = '{ACT_AVG,    COND_ALWAYS,    ADDR_FIN};
      default:       uw = '{ACT_NOP,    COND_ALWAYS,    ADDR_IDLE};
    endcase
    return uw;
  endfunction

  function automatic logic [PC_W-1:0] dispatch_addr(logic [OP_W-1:0] op);
    logic [PC_W-1:0] a;
    unique case (op)
      OP_RESEED: a = ADDR_MOD;
      OP_LOAD:   a = ADDR_LOAD;
      OP_RAW:    a = ADDR_RAW;
      OP_RANGED: a = ADDR_RANGED;
      OP_ROLL:   a = ADDR_ROLL;
      OP_ROLL2:  a = ADDR_ROLL2;
      default:   a = ADDR_FIN;
    endcase
    return a;
  endfunction

endpackage

/* hdl/srs_chan_if.sv */
// valid/ready channel carrying one payload beat
// payload type is supplied by the instantiating level, normally from srs_pkg
interface srs_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/shift_register_random_source.sv */
// shift-register random source: 48-bit generator driven by a microcoded sequencer
// depends on srs_pkg and srs_chan_if
//
// usage
//   in_chan carries one command beat (op, seed, max_value, threshold, load words);
//   out_chan returns exactly one result beat per command: value, hit and the
//   three generator words after the operation.
//   a command is taken only while the sequencer sits at its idle step; a result
//   waits in an output register, so the next command is taken while it is pending.
// program paths from dispatch to the finish step
//   unused ops: straight to finish; load: load step; raw draw: a draw; ranged draw, single roll: draw, multiply
//   double roll: draw, multiply, save, draw, multiply, average
//   reseed: residue steps, seed load, then, if n > 0, n burn steps (n up to 22) and a no-op step;
//   the seed residues take three steps: digit folding, reciprocal multiply, subtract
// one command at a time: the next command can be taken in the cycle after the result
//   is posted; each generator step and multiply is one control step of the program
// reset: generator words clear to zero, sequencer returns to idle, no result pending
// stall: a finished command holds at its last step until the output register frees
module shift_register_random_source (
  input  logic        clk,
  input  logic        rst_n,
  srs_chan_if.sink    in_chan,
  srs_chan_if.source  out_chan
);
  import srs_pkg::*;

  logic [PC_W-1:0]     pc_r, pc_nxt;
  srs_in_t             cmd_r;
  logic [WORD_W-1:0]   w0_r, w1_r, w2_r;
  logic [WORD_W-1:0]   value_r;
  logic [ROLL_W-1:0]   a_r;
  logic [SUM7_W-1:0]   sum7_r;
  logic [SUM23_W-1:0]  sum23_r;
  logic [QUOT23_W-1:0] quot23_r;
  logic [MOD7_W-1:0]   r7_r;
  logic [MOD23_W-1:0]  r23_r;
  logic                out_valid_r;
  srs_out_t            out_data_r;

  uword_t              uw;
  logic                in_fire, out_busy, taken, post;
  logic [WORD_W-1:0]   gen_num;
  logic [SUM7_W-1:0]   sum7;
  logic [SUM23_W-1:0]  sum23;
  logic [MOD7_W:0]     fold7a, fold7b;
  logic [MOD7_W-1:0]   r7_fold;
  logic [2*SUM23_W-1:0] prod_q;
  logic [SUM23_W-1:0]  rem23;
  logic [WORD_W+MAXV_W-1:0] prod_max;
  logic [WORD_W+ROLL_W-1:0] prod_100;
  logic [ROLL_W:0]     avg_sum;
  logic                hit;

  assign uw       = ucode(pc_r);
  assign in_chan.ready = (pc_r == ADDR_IDLE);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_busy = out_valid_r && !out_chan.ready;
  assign post     = (uw.act == ACT_FINISH) && !out_busy;

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // generator step
  assign gen_num = (({w1_r[4:0], 11'b0}) + ({5'b0, w0_r[WORD_W-1:5]}))
                   ^ {w2_r[WORD_W-2:0], w1_r[WORD_W-1]};

  // seed residues: 8 = 1 mod 7 and 2048 = 1 mod 23, so digit sums keep the residue
  always_comb begin
    sum7 = SUM7_W'(cmd_r.seed[SEED_W-1]);
    for (int d = 0; d < SEED_DIGITS; d++) begin
      sum7 = sum7 + SUM7_W'(cmd_r.seed[MOD7_W*d +: MOD7_W]);
    end
  end

  assign sum23   = SUM23_W'(cmd_r.seed[CHUNK23_W-1:0])
                 + SUM23_W'(cmd_r.seed[2*CHUNK23_W-1:CHUNK23_W])
                 + SUM23_W'(cmd_r.seed[SEED_W-1:2*CHUNK23_W]);
  assign fold7a  = sum7_r[SUM7_W-1:MOD7_W] + {1'b0, sum7_r[MOD7_W-1:0]};
  assign fold7b  = {{MOD7_W{1'b0}}, fold7a[MOD7_W]} + {1'b0, fold7a[MOD7_W-1:0]};
  assign r7_fold = (fold7b >= {1'b0, MOD_SMALL}) ? MOD7_W'(fold7b - {1'b0, MOD_SMALL})
                                                 : fold7b[MOD7_W-1:0];
  assign prod_q  = sum23_r * RECIP23;
  assign rem23   = sum23_r - SUM23_W'(quot23_r) * SUM23_W'(MOD_LARGE);

  assign prod_max = value_r * cmd_r.max_value;
  assign prod_100 = value_r * ROLL_SCALE;
  assign avg_sum  = {1'b0, a_r} + {1'b0, value_r[ROLL_W-1:0]};
  assign hit      = ((cmd_r.op == OP_ROLL) || (cmd_r.op == OP_ROLL2))
                    && ({{(WORD_W-THR_W){1'b0}}, cmd_r.threshold} > value_r);

  always_comb begin
    unique case (uw.cond)
      COND_NEXT:      taken = 1'b0;
      COND_ALWAYS:    taken = 1'b1;
      COND_OUT_BUSY:  taken = out_busy;
      COND_NO_IN:     taken = !in_fire;
      COND_DISPATCH:  taken = 1'b1;
      COND_BURN_NONE: taken = (r23_r == '0);
      COND_BURN_MORE: taken = (r23_r != MOD23_W'(1));
      default:        taken = 1'b0;
    endcase
    if (!taken) begin
      pc_nxt = pc_r + PC_W'(1);
    end else if (uw.cond == COND_DISPATCH) begin
      pc_nxt = dispatch_addr(cmd_r.op);
    end else begin
      pc_nxt = uw.target;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ADDR_IDLE;
      out_valid_r <= 1'b0;
      w0_r        <= '0;
      w1_r        <= '0;
      w2_r        <= '0;
    end else begin
      pc_r <= pc_nxt;
      if (post) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (uw.act)
        ACT_LATCH: begin
          if (in_fire) begin
            cmd_r    <= in_chan.data;
            value_r  <= '0;
            r7_r     <= '0;
            r23_r    <= '0;
          end
        end
        ACT_FOLD: begin
          sum7_r  <= sum7;
          sum23_r <= sum23;
        end
        ACT_QUOT: begin
          r7_r     <= r7_fold;
          quot23_r <= prod_q[RECIP23_SHIFT+QUOT23_W-1:RECIP23_SHIFT];
        end
        ACT_RESID: r23_r <= rem23[MOD23_W-1:0];
        ACT_SEEDLD: begin
          w0_r <= SEED_TABLE[r7_r];
          w1_r <= SEED_TABLE[r7_r + MOD7_W'(1)];
          w2_r <= SEED_TABLE[r7_r + MOD7_W'(2)];
        end
        ACT_BURN: begin
          w0_r  <= gen_num;
          w1_r  <= w0_r;
          w2_r  <= w1_r;
          r23_r <= r23_r - MOD23_W'(1);
        end
        ACT_LOAD: begin
          w0_r <= cmd_r.load_low;
          w1_r <= cmd_r.load_mid;
          w2_r <= cmd_r.load_high;
        end
        ACT_GEN: begin
          w0_r    <= gen_num;
          w1_r    <= w0_r;
          w2_r    <= w1_r;
          value_r <= gen_num;
        end
        ACT_MULMAX: value_r <= {1'b0, prod_max[WORD_W+MAXV_W-1:WORD_W]};
        ACT_MUL100: value_r <= {{(WORD_W-ROLL_W){1'b0}}, prod_100[WORD_W+ROLL_W-1:WORD_W]};
        ACT_SAVEA:  a_r <= value_r[ROLL_W-1:0];
        ACT_AVG:    value_r <= {{(WORD_W-ROLL_W){1'b0}}, avg_sum[ROLL_W:1]};
        ACT_FINISH: begin
          if (!out_busy) begin
            out_data_r.value      <= value_r;
            out_data_r.hit        <= hit;
            out_data_r.state_low  <= w0_r;
            out_data_r.state_mid  <= w1_r;
            out_data_r.state_high <= w2_r;
          end
        end
        default: ;
      endcase
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (pc_r == ADDR_DISPATCH))
    else $error("accepted command did not reach dispatch");

  a_residues_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ADDR_SEEDLD) |-> ((r7_r < MOD_SMALL) && (r23_r < MOD_LARGE)))
    else $error("seed residue out of range");

  a_burn_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ADDR_BURN) |-> (r23_r != '0))
    else $error("burn step entered with zero count");

  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((pc_r == ADDR_FIN) && !out_busy) |=> (out_valid_r && (pc_r == ADDR_IDLE)))
    else $error("finished command did not post a result");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r != ADDR_IDLE) |-> !in_fire)
    else $error("command taken while sequencer busy");

endmodule

/* sim/shift_register_random_source_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for shift_register_random_source: directed, back-pressure
// and random command phases, checked against an in-bench generator model
// depends on srs_pkg, srs_chan_if and the block itself
module shift_register_random_source_tb;
  import srs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 80;

  logic clk;
  logic rst_n;

  srs_chan_if #(.payload_t(srs_in_t))  in_if ();
  srs_chan_if #(.payload_t(srs_out_t)) out_if ();

  shift_register_random_source uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  logic [WORD_W-1:0] gen_shadow [3];
  srs_out_t          expected_draws [$];

  bit src_idle_en;
  bit snk_idle_en;
  int hold_request;
  int stall_left;
  int quiet_cycles;
  int sent_count;
  int checked_count;
  int mismatch_count;
  int hit_count;
  int op_seen [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one step of the 48-bit shift generator on the shadow words
  function automatic logic [WORD_W-1:0] advance_generator();
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] fold;
    num  = {gen_shadow[1][4:0], 11'b0} + (gen_shadow[0] >> 5);
    fold = {gen_shadow[2][WORD_W-2:0], gen_shadow[1][WORD_W-1]};
    num  = num ^ fold;
    gen_shadow[2] = gen_shadow[1];
    gen_shadow[1] = gen_shadow[0];
    gen_shadow[0] = num;
    return num;
  endfunction

  function automatic logic [WORD_W-1:0] percent_draw();
    logic [31:0] prod;
    prod = 32'(advance_generator()) * 32'(ROLL_SCALE);
    return prod[31:16];
  endfunction

  function automatic srs_out_t predict_draw(input srs_in_t c);
    srs_out_t    r;
    logic [31:0] prod;
    logic [2:0]  k;
    int          burn;
    logic [WORD_W:0] pair;
    r = '0;
    case (c.op)
      OP_RESEED: begin
        k    = 3'(c.seed % 7);
        burn = int'(c.seed % 23);
        gen_shadow[0] = SEED_TABLE[k];
        gen_shadow[1] = SEED_TABLE[3'(k + 3'd1)];
        gen_shadow[2] = SEED_TABLE[3'(k + 3'd2)];
        for (int i = 0; i < burn; i++) void'(advance_generator());
      end
      OP_LOAD: begin
        gen_shadow[0] = c.load_low;
        gen_shadow[1] = c.load_mid;
        gen_shadow[2] = c.load_high;
      end
      OP_RAW: r.value = advance_generator();
      OP_RANGED: begin
        prod    = 32'(advance_generator()) * 32'(c.max_value);
        r.value = prod[31:16];
      end
      OP_ROLL: begin
        r.value = percent_draw();
        r.hit   = (16'(c.threshold) > r.value);
      end
      OP_ROLL2: begin
        pair    = 17'(percent_draw());
        pair    = pair + 17'(percent_draw());
        r.value = pair[WORD_W:1];
        r.hit   = (16'(c.threshold) > r.value);
      end
      default: ;
    endcase
    r.state_low  = gen_shadow[0];
    r.state_mid  = gen_shadow[1];
    r.state_high = gen_shadow[2];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch on %s at result %0d: expected %h, got %h",
             what, checked_count, want, got);
    mismatch_count++;
  endtask

  // offer one command beat and wait for it to be taken
  task automatic send_cmd(input srs_in_t c);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= c;
    do @(posedge clk); while (!in_if.ready);
    expected_draws.push_back(predict_draw(c));
    op_seen[c.op]++;
    sent_count++;
  endtask

  function automatic srs_in_t make_cmd(input logic [OP_W-1:0] op);
    srs_in_t c;
    c.op        = op;
    c.seed      = ($urandom_range(0, 3) == 0) ? SEED_W'($urandom_range(0, 400))
                                               : SEED_W'($urandom());
    c.max_value = MAXV_W'($urandom());
    c.threshold = ($urandom_range(0, 1) == 0) ? THR_W'($urandom_range(0, 101))
                                               : THR_W'($urandom());
    c.load_low  = WORD_W'($urandom());
    c.load_mid  = WORD_W'($urandom());
    c.load_high = WORD_W'($urandom());
    if (op == OP_LOAD && $urandom_range(0, 9) == 0) begin
      c.load_low  = '0;
      c.load_mid  = '0;
      c.load_high = '0;
    end
    if (op == OP_RANGED && $urandom_range(0, 9) == 0)
      c.max_value = ($urandom_range(0, 1) == 0) ? '0 : '1;
    return c;
  endfunction

  function automatic srs_in_t random_cmd();
    int pick;
    logic [OP_W-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 8)       op = OP_RESEED;
    else if (pick < 18) op = OP_LOAD;
    else if (pick < 36) op = OP_RAW;
    else if (pick < 54) op = OP_RANGED;
    else if (pick < 74) op = OP_ROLL;
    else if (pick < 94) op = OP_ROLL2;
    else if (pick < 97) op = OP_UNUSED_LO;
    else                op = OP_UNUSED_HI;
    return make_cmd(op);
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic [SEED_W-1:0] seed,
                         input logic [MAXV_W-1:0] maxv, input logic [THR_W-1:0] thr);
    srs_in_t c;
    c           = make_cmd(op);
    c.seed      = seed;
    c.max_value = maxv;
    c.threshold = thr;
    send_cmd(c);
  endtask

  task automatic test_directed();
    srs_in_t c;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    // unseeded generator stays at zero
    send_op(OP_RAW, '0, '1, 8'd0);
    send_op(OP_ROLL, '0, '0, 8'd1);
    send_op(OP_UNUSED_LO, '1, '1, '1);
    c = make_cmd(OP_LOAD);
    c.load_low  = '1;
    c.load_mid  = '1;
    c.load_high = '1;
    send_cmd(c);
    send_op(OP_RAW, '0, '0, '0);
    send_op(OP_RANGED, '0, '0, '0);
    send_op(OP_RANGED, '0, '1, '0);
    c = make_cmd(OP_LOAD);
    c.load_low  = '0;
    c.load_mid  = '0;
    c.load_high = '0;
    send_cmd(c);
    send_op(OP_UNUSED_HI, '0, '0, '0);
    // reseed extremes: zero, all ones, table wrap, longest burn, no burn
    send_op(OP_RESEED, '0, '0, '0);
    send_op(OP_RESEED, '1, '0, '0);
    send_op(OP_RESEED, 31'd6, '0, '0);
    send_op(OP_RESEED, 31'd22, '0, '0);
    send_op(OP_RESEED, 31'd161, '0, '0);
    send_op(OP_RANGED, '0, '1, '0);
    send_op(OP_RANGED, '0, '0, '0);
    send_op(OP_ROLL, '0, '0, 8'd0);
    send_op(OP_ROLL, '0, '0, 8'd255);
    send_op(OP_ROLL2, '0, '0, 8'd0);
    send_op(OP_ROLL2, '0, '0, 8'd255);
    send_op(OP_ROLL2, '0, '0, 8'd50);
    send_op(OP_RAW, '0, '0, '0);
  endtask

  // receiver holds off while commands keep coming, so the block backs up
  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) send_cmd(random_cmd());
  endtask

  task automatic test_random(input int count, input bit with_idle);
    src_idle_en = with_idle;
    snk_idle_en = with_idle;
    for (int i = 0; i < count; i++) send_cmd(random_cmd());
  endtask

  // receiver side: random stalls and the long hold-off
  initial begin
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    srs_out_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_draws.size() == 0) begin
        report_mismatch("unexpected beat", 32'd0, 32'(out_if.data.value));
      end else begin
        want = expected_draws.pop_front();
        if (out_if.data.value !== want.value)
          report_mismatch("value", 32'(want.value), 32'(out_if.data.value));
        if (out_if.data.hit !== want.hit)
          report_mismatch("hit", 32'(want.hit), 32'(out_if.data.hit));
        if (out_if.data.state_low !== want.state_low)
          report_mismatch("state_low", 32'(want.state_low), 32'(out_if.data.state_low));
        if (out_if.data.state_mid !== want.state_mid)
          report_mismatch("state_mid", 32'(want.state_mid), 32'(out_if.data.state_mid));
        if (out_if.data.state_high !== want.state_high)
          report_mismatch("state_high", 32'(want.state_high), 32'(out_if.data.state_high));
        if (want.hit) hit_count++;
      end
      checked_count++;
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_draws.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    quiet_cycles = 0;
    hold_request = 0;
    src_idle_en  = 1'b0;
    snk_idle_en  = 1'b0;
    gen_shadow[0] = '0;
    gen_shadow[1] = '0;
    gen_shadow[2] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random(580, 1'b1);
    test_random(140, 1'b0);

    in_if.valid <= 1'b0;
    wait (expected_draws.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_draws.size() != 0)
      report_mismatch("missing results", 32'd0, 32'(expected_draws.size()));

    $display("covered %0d commands (reseed %0d, load %0d, raw %0d, ranged %0d, roll %0d,",
             sent_count, op_seen[OP_RESEED], op_seen[OP_LOAD], op_seen[OP_RAW],
             op_seen[OP_RANGED], op_seen[OP_ROLL]);
    $display("  double roll %0d, unused %0d); %0d results checked, %0d hits, %0d mismatches",
             op_seen[OP_ROLL2], op_seen[OP_UNUSED_LO] + op_seen[OP_UNUSED_HI],
             checked_count, hit_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* shift_register_random_source.f */
hdl/srs_pkg.sv
hdl/srs_chan_if.sv
hdl/shift_register_random_source.sv
sim/shift_register_random_source_tb.sv
